// ----- rtl/core/bns_pkg.sv -----
// Package for the banded noise synthesizer core.
// Holds sequencer state type, register indexes and fixed constants; no dependencies.
package bns_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SEED      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_FLOW      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_INV_AREA  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_GAIN      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SLOW_COEF = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_FAST_COEF = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_NORM      = 3'd7;

    localparam logic [31:0] SEED_DEFAULT = 32'h6d2b79f5;
    localparam logic [31:0] SQRT3_Q30    = 32'd1859775393;
    localparam logic [24:0] PRESSURE_CAP = 25'd25600000;
    localparam logic [24:0] COEF_ONE     = 25'd16777216;
    localparam logic [22:0] NORM_MAX     = 23'd4194304;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SM_FLOW, S_SM_AREA, S_SM_GAIN, S_SM_SLOW, S_SM_FAST, S_SM_NORM,
        S_VEL, S_VSQ, S_T, S_P,
        S_NOISE, S_WHITE, S_LP_SLOW, S_LP_FAST, S_DIFF, S_OUT, S_DONE
    } t_state;

endpackage

// ----- rtl/core/bns_mul.sv -----
// Shared 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// Depends on nothing; driven by the top-level sequencer.
module bns_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [127:0]  o_prod
);
    logic [1:0]   r_step;
    logic         r_busy;
    logic         r_done;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [31:0]  w_x;
    logic [31:0]  w_y;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    always_comb begin
        w_x = r_step[0] ? r_a[63:32] : r_a[31:0];
        w_y = r_step[1] ? r_b[63:32] : r_b[31:0];
        w_pp = {32'd0, w_x} * {32'd0, w_y};
        w_sh = {64'd0, w_pp} << ({6'd0, r_step[0]} * 7'd32 + {6'd0, r_step[1]} * 7'd32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc  <= r_acc + w_sh;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ----- rtl/core/banded_noise_synth_with_ramped_gain_core.sv -----
// Top level of the banded noise synthesizer core: config registers, sequencer, datapath.
// Depends on bns_pkg and bns_mul.
//
// Usage: write the eight registers through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// Each input item on the s_axis channel (tdata: ramp[16:0], restart[17]) yields exactly
// one output item on m_axis (tdata: sample[33:0], signed). Items run one at a time
// through the shared 64x64 multiplier; each product is started, summed from four 32x32
// partial products and flagged done. An enabled item uses 21 products; with zero
// pressure it stops after 16 products and presents a zero; a disabled item goes
// straight to the done state and presents a zero.
// s_axis_tready is high only while the sequencer is idle and the output register is empty,
// so the next item can be taken the cycle after the result leaves.
// If the receiver stalls, the result holds in the output register and no new item
// is taken until it leaves. Reset loads the seed default into the noise register,
// clears filters and working parameters, and clears enable.
//
module banded_noise_synth_with_ramped_gain_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [bns_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // ramp[16:0], restart[17], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // sample[33:0], zero fill
);
    import bns_pkg::*;

    t_state r_state, n_state;

    logic        r_enable;
    logic [31:0] r_seed, r_flow_t, r_area_t;
    logic [47:0] r_gain_t;
    logic [24:0] r_slow_t, r_fast_t;
    logic [22:0] r_norm_t;

    logic [31:0] r_noise;
    logic signed [31:0] r_slow_lp, r_fast_lp;
    logic [31:0] r_flow, r_area;
    logic [47:0] r_gain;
    logic [24:0] r_slow_c, r_fast_c;
    logic [22:0] r_norm;
    logic [16:0] r_ramp;
    logic [63:0] r_vel, r_vsq, r_t;
    logic [24:0] r_p;
    logic signed [31:0] r_white;
    logic signed [63:0] r_d;
    logic [33:0] r_out;
    logic        r_ovalid;
    logic        r_wait;

    logic         w_start, w_mdone;
    logic [63:0]  w_a, w_b;
    logic [127:0] w_prod;
    logic [127:0] w_sprod;

    logic        w_take;
    logic [16:0] w_r;
    logic [31:0] w_seedv;
    logic [31:0] w_x1, w_x2, w_x3;

    assign w_take = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign w_r = (s_axis_tdata[16:0] > 17'd65536) ? 17'd65536 : s_axis_tdata[16:0];
    assign w_seedv = (r_seed != 32'd0) ? r_seed : SEED_DEFAULT;
    assign w_x1 = r_noise ^ (r_noise << 13);
    assign w_x2 = w_x1 ^ (w_x1 >> 17);
    assign w_x3 = w_x2 ^ (w_x2 << 5);
    assign w_sprod = w_prod;

    bns_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_done (w_mdone),
        .o_prod (w_prod)
    );

    // signed operands travel as magnitudes with a separate sign flag; sign applied when shifting
    logic [16:0] w_nr;
    logic [24:0] w_sc, w_fc;
    logic [22:0] w_nm;
    logic signed [32:0] w_ndiff;
    logic signed [32:0] w_lpd;
    logic signed [32:0] w_ld;
    logic        w_neg;
    logic [63:0] w_absb;
    logic [63:0] w_absa;
    assign w_nr = 17'd65536 - r_ramp;
    assign w_sc = (r_slow_c > COEF_ONE) ? COEF_ONE : r_slow_c;
    assign w_fc = (r_fast_c > COEF_ONE) ? COEF_ONE : r_fast_c;
    assign w_nm = (r_norm > NORM_MAX) ? NORM_MAX : r_norm;
    assign w_ndiff = {r_noise, 1'b1} - 33'sh1_0000_0000;
    assign w_lpd = (r_state == S_LP_SLOW) ? ({r_white[31], r_white} - {r_slow_lp[31], r_slow_lp})
                                          : ({r_white[31], r_white} - {r_fast_lp[31], r_fast_lp});
    assign w_ld = {r_fast_lp[31], r_fast_lp} - {r_slow_lp[31], r_slow_lp};

    // smoothing uses two products: now*(1-r) into r_acc first, then target*r added to it
    logic [63:0] r_acc;
    logic        r_half;
    logic [47:0] w_now, w_tgt;

    always_comb begin
        w_now = '0;
        w_tgt = '0;
        unique case (r_state)
            S_SM_FLOW: begin w_now = {16'd0, r_flow};   w_tgt = {16'd0, r_flow_t}; end
            S_SM_AREA: begin w_now = {16'd0, r_area};   w_tgt = {16'd0, r_area_t}; end
            S_SM_GAIN: begin w_now = r_gain;            w_tgt = r_gain_t;          end
            S_SM_SLOW: begin w_now = {23'd0, r_slow_c}; w_tgt = {23'd0, r_slow_t}; end
            S_SM_FAST: begin w_now = {23'd0, r_fast_c}; w_tgt = {23'd0, r_fast_t}; end
            S_SM_NORM: begin w_now = {25'd0, r_norm};   w_tgt = {25'd0, r_norm_t}; end
            default: ;
        endcase
    end

    always_comb begin
        w_neg = 1'b0;
        w_absa = '0;
        w_absb = '0;
        unique case (r_state)
            S_SM_FLOW, S_SM_AREA, S_SM_GAIN, S_SM_SLOW, S_SM_FAST, S_SM_NORM: begin
                w_absa = {16'd0, (r_half ? w_tgt : w_now)};
                w_absb = {47'd0, (r_half ? r_ramp : w_nr)};
            end
            S_VEL:  begin w_absa = {32'd0, r_flow}; w_absb = {32'd0, r_area}; end
            S_VSQ:  begin w_absa = r_vel; w_absb = r_vel; end
            S_T:    begin w_absa = {16'd0, r_gain}; w_absb = r_vsq; end
            S_P:    begin w_absa = r_t; w_absb = r_vsq; end
            S_WHITE: begin
                w_neg  = w_ndiff[32];
                w_absa = {31'd0, (w_ndiff[32] ? -w_ndiff : w_ndiff)};
                w_absb = {32'd0, SQRT3_Q30};
            end
            S_LP_SLOW, S_LP_FAST: begin
                w_neg  = w_lpd[32];
                w_absa = {31'd0, (w_lpd[32] ? -w_lpd : w_lpd)};
                w_absb = {39'd0, (r_state == S_LP_SLOW ? w_sc : w_fc)};
            end
            S_DIFF: begin
                w_neg  = w_ld[32];
                w_absa = {31'd0, (w_ld[32] ? -w_ld : w_ld)};
                w_absb = {41'd0, w_nm};
            end
            S_OUT: begin
                w_neg  = r_d[63];
                w_absa = r_d[63] ? -r_d : r_d;
                w_absb = {39'd0, r_p};
            end
            default: ;
        endcase
    end

    assign w_a = w_absa;
    assign w_b = w_absb;
    assign w_start = !r_wait && (r_state != S_IDLE) && (r_state != S_NOISE)
                     && (r_state != S_DONE);

    // floor shift of a signed magnitude product
    function automatic logic signed [127:0] fshift(input logic [127:0] m, input logic neg,
                                                   input int unsigned sh);
        logic [127:0] q;
        logic [127:0] rem;
        begin
            q = m >> sh;
            rem = m & ((128'd1 << sh) - 128'd1);
            if (neg) fshift = -$signed(q + {127'd0, (rem != 128'd0)});
            else     fshift = $signed(q);
        end
    endfunction

    logic signed [127:0] w_sres;
    logic [63:0] w_sm;
    always_comb begin
        w_sres = '0;
        unique case (r_state)
            S_WHITE:   w_sres = fshift(w_sprod, w_neg, 33);
            S_LP_SLOW, S_LP_FAST: w_sres = fshift(w_sprod, w_neg, 24);
            S_DIFF:    w_sres = fshift(w_sprod, w_neg, 21);
            S_OUT:     w_sres = fshift(w_sprod, w_neg, 24);
            default:   w_sres = '0;
        endcase
        w_sm = r_acc + w_sprod[63:0];
    end

    function automatic logic [63:0] satsh(input logic [127:0] m, input int unsigned sh);
        logic [127:0] q;
        begin
            q = m >> sh;
            satsh = (q[127:64] != 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
        end
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_take) n_state = s_axis_tdata[17] || r_enable ?
                           (r_enable ? S_SM_FLOW : S_DONE) : S_DONE;
            S_SM_FLOW: if (w_mdone && r_half) n_state = S_SM_AREA;
            S_SM_AREA: if (w_mdone && r_half) n_state = S_SM_GAIN;
            S_SM_GAIN: if (w_mdone && r_half) n_state = S_SM_SLOW;
            S_SM_SLOW: if (w_mdone && r_half) n_state = S_SM_FAST;
            S_SM_FAST: if (w_mdone && r_half) n_state = S_SM_NORM;
            S_SM_NORM: if (w_mdone && r_half) n_state = S_VEL;
            S_VEL:     if (w_mdone) n_state = S_VSQ;
            S_VSQ:     if (w_mdone) n_state = S_T;
            S_T:       if (w_mdone) n_state = S_P;
            S_P: begin
                if (w_mdone) begin
                    if (satsh(w_sprod, 56) == 64'd0) n_state = S_DONE;
                    else n_state = S_NOISE;
                end
            end
            S_NOISE:   n_state = S_WHITE;
            S_WHITE:   if (w_mdone) n_state = S_LP_SLOW;
            S_LP_SLOW: if (w_mdone) n_state = S_LP_FAST;
            S_LP_FAST: if (w_mdone) n_state = S_DIFF;
            S_DIFF:    if (w_mdone) n_state = S_OUT;
            S_OUT:     if (w_mdone) n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    logic [63:0] w_pc;
    always_comb begin
        w_pc = satsh(w_sprod, 56);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_enable <= 1'b0;
            r_seed   <= SEED_DEFAULT;
            r_noise  <= SEED_DEFAULT;
            r_flow_t <= '0; r_area_t <= '0; r_gain_t <= '0;
            r_slow_t <= '0; r_fast_t <= '0; r_norm_t <= '0;
            r_slow_lp <= '0; r_fast_lp <= '0;
            r_flow <= '0; r_area <= '0; r_gain <= '0;
            r_slow_c <= '0; r_fast_c <= '0; r_norm <= '0;
            r_out    <= '0;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
            r_half   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ENABLE:    r_enable <= i_cfg_data[0];
                    REG_SEED: begin
                        r_seed  <= i_cfg_data[31:0];
                        r_noise <= (i_cfg_data[31:0] != 32'd0) ? i_cfg_data[31:0] : SEED_DEFAULT;
                    end
                    REG_FLOW:      r_flow_t <= i_cfg_data[31:0];
                    REG_INV_AREA:  r_area_t <= i_cfg_data[31:0];
                    REG_GAIN:      r_gain_t <= i_cfg_data;
                    REG_SLOW_COEF: r_slow_t <= i_cfg_data[24:0];
                    REG_FAST_COEF: r_fast_t <= i_cfg_data[24:0];
                    REG_NORM:      r_norm_t <= i_cfg_data[22:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (w_start) r_wait <= 1'b1;
            if (w_mdone) r_wait <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_half <= 1'b0;
                    if (w_take) begin
                        r_out  <= '0;
                        r_ramp <= w_r;
                        if (s_axis_tdata[17]) begin
                            r_flow <= r_flow_t; r_area <= r_area_t; r_gain <= r_gain_t;
                            r_slow_c <= r_slow_t; r_fast_c <= r_fast_t; r_norm <= r_norm_t;
                            r_slow_lp <= '0; r_fast_lp <= '0;
                            r_noise <= w_seedv;
                        end
                    end
                end
                S_SM_FLOW, S_SM_AREA, S_SM_GAIN, S_SM_SLOW, S_SM_FAST, S_SM_NORM: begin
                    if (w_mdone) begin
                        r_half <= !r_half;
                        if (!r_half) r_acc <= w_sprod[63:0];
                        else begin
                            unique case (r_state)
                                S_SM_FLOW: r_flow   <= w_sm[47:16];
                                S_SM_AREA: r_area   <= w_sm[47:16];
                                S_SM_GAIN: r_gain   <= w_sm[63:16];
                                S_SM_SLOW: r_slow_c <= w_sm[40:16];
                                S_SM_FAST: r_fast_c <= w_sm[40:16];
                                default:   r_norm   <= w_sm[38:16];
                            endcase
                        end
                    end
                end
                S_VEL: if (w_mdone) r_vel <= satsh(w_sprod, 24);
                S_VSQ: if (w_mdone) r_vsq <= satsh(w_sprod, 16);
                S_T:   if (w_mdone) r_t   <= satsh(w_sprod, 16);
                S_P:   if (w_mdone) r_p   <= (w_pc > {39'd0, PRESSURE_CAP}) ? PRESSURE_CAP
                                                                        : w_pc[24:0];
                S_NOISE: r_noise <= w_x3;
                S_WHITE: if (w_mdone) r_white <= w_sres[31:0];
                S_LP_SLOW: if (w_mdone) r_slow_lp <= r_slow_lp + w_sres[31:0];
                S_LP_FAST: if (w_mdone) r_fast_lp <= r_fast_lp + w_sres[31:0];
                S_DIFF: if (w_mdone) r_d <= w_sres[63:0];
                S_OUT: begin
                    if (w_mdone) begin
                        if (w_sres > 128'sh1_FFFF_FFFF)       r_out <= 34'h1_FFFF_FFFF;
                        else if (w_sres < -128'sh2_0000_0000) r_out <= 34'h2_0000_0000;
                        else                                   r_out <= w_sres[33:0];
                    end
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_out};

    property p_one_out;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_DONE) |=> m_axis_tvalid;
    endproperty
    a_one_out: assert property (p_one_out) else $error("result not presented");

    property p_busy_closed;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state != S_IDLE) |-> !s_axis_tready;
    endproperty
    a_busy_closed: assert property (p_busy_closed) else $error("input open while busy");

    property p_mul_single;
        @(posedge i_clk) disable iff (!i_rst_n) w_start |-> !r_wait;
    endproperty
    a_mul_single: assert property (p_mul_single) else $error("multiplier reissued");

endmodule

// ----- tb/sv/tb_banded_noise_synth_with_ramped_gain_core.sv -----
// Testbench for banded_noise_synth_with_ramped_gain_core: drives config writes and ramp/restart
// items, predicts each sample with a bit-exact model of the core and checks it in order.
// Depends on bns_pkg and the core RTL.
module tb_banded_noise_synth_with_ramped_gain_core;
    import bns_pkg::*;

    class sample_scoreboard;
        logic [31:0] en, seed, flow_t, area_t, slow_t, fast_t;
        logic [47:0] gain_t;
        logic [22:0] norm_t;
        logic [31:0] noise;
        longint slow_lp, fast_lp;
        logic [63:0] flow_n, area_n, gain_n, slow_n, fast_n, norm_n;
        logic [33:0] pending[$];
        int errors;
        int checked;
        int nonzero;

        function new();
            en = 0; seed = SEED_DEFAULT; flow_t = 0; area_t = 0; gain_t = 0;
            slow_t = 0; fast_t = 0; norm_t = 0; noise = SEED_DEFAULT;
            slow_lp = 0; fast_lp = 0;
            flow_n = 0; area_n = 0; gain_n = 0; slow_n = 0; fast_n = 0; norm_n = 0;
            errors = 0; checked = 0; nonzero = 0;
        endfunction

        function logic [31:0] seed_val();
            return (seed != 0) ? seed : SEED_DEFAULT;
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] v);
            case (idx)
                REG_ENABLE:    en = {31'd0, v[0]};
                REG_SEED:      begin seed = v[31:0]; noise = seed_val(); end
                REG_FLOW:      flow_t = v[31:0];
                REG_INV_AREA:  area_t = v[31:0];
                REG_GAIN:      gain_t = v;
                REG_SLOW_COEF: slow_t = {7'd0, v[24:0]};
                REG_FAST_COEF: fast_t = {7'd0, v[24:0]};
                REG_NORM:      norm_t = v[22:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, int sh,
                                      logic [63:0] cap);
            logic [127:0] p;
            p = ({64'd0, a} * {64'd0, b}) >> sh;
            if (p[127:64] != 0 || p[63:0] > cap) return cap;
            return p[63:0];
        endfunction

        function logic [63:0] ease(logic [63:0] now, logic [63:0] tgt, logic [63:0] r);
            return (now * (64'd65536 - r) + tgt * r) >> 16;
        endfunction

        function void note_item(logic [16:0] ramp, logic restart);
            logic [63:0] r, vel, vsq, t, p, sc, fc, nm;
            logic [31:0] x;
            longint n, white, d, y;
            logic signed [127:0] wide;
            r = (ramp > 17'd65536) ? 64'd65536 : {47'd0, ramp};
            if (restart) begin
                flow_n = flow_t; area_n = area_t; gain_n = gain_t;
                slow_n = slow_t; fast_n = fast_t; norm_n = norm_t;
                slow_lp = 0; fast_lp = 0; noise = seed_val();
            end
            if (!en[0]) begin pending.push_back('0); return; end
            flow_n = ease(flow_n, flow_t, r);
            area_n = ease(area_n, area_t, r);
            gain_n = ease(gain_n, gain_t, r);
            slow_n = ease(slow_n, slow_t, r);
            fast_n = ease(fast_n, fast_t, r);
            norm_n = ease(norm_n, norm_t, r);
            vel = mul_sat(flow_n, area_n, 24, '1);
            vsq = mul_sat(vel, vel, 16, '1);
            t = mul_sat(gain_n, vsq, 16, '1);
            p = mul_sat(t, vsq, 56, 64'd25600000);
            if (p == 0) begin pending.push_back('0); return; end
            x = noise;
            x ^= x << 13;
            x ^= x >> 17;
            x ^= x << 5;
            noise = x;
            n = 2 * longint'({32'd0, x}) - 64'sd4294967296 + 1;
            white = (n * 64'sd1859775393) >>> 33;
            sc = (slow_n > 64'd16777216) ? 64'd16777216 : slow_n;
            fc = (fast_n > 64'd16777216) ? 64'd16777216 : fast_n;
            nm = (norm_n > 64'd4194304) ? 64'd4194304 : norm_n;
            slow_lp += (longint'(sc) * (white - slow_lp)) >>> 24;
            fast_lp += (longint'(fc) * (white - fast_lp)) >>> 24;
            d = ((fast_lp - slow_lp) * longint'(nm)) >>> 21;
            wide = (128'(signed'(d)) * 128'(signed'(p))) >>> 24;
            if (wide > 128'sd8589934591) y = 64'sd8589934591;
            else if (wide < -128'sd8589934592) y = -64'sd8589934592;
            else y = longint'(wide);
            pending.push_back(y[33:0]);
        endfunction

        function void check_sample(logic [33:0] got);
            logic [33:0] exp_s;
            if (pending.size() == 0) begin
                $display("%0t: unexpected sample %h", $time, got);
                errors++;
                return;
            end
            exp_s = pending.pop_front();
            checked++;
            if (got != 0) nonzero++;
            if (got !== exp_s) begin
                $display("%0t: sample mismatch expected %h actual %h", $time, exp_s, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [47:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    sample_scoreboard sb;
    int  cycles;
    int  rx_cycles;
    bit  hold_rx;
    bit  stim_done;

    banded_noise_synth_with_ramped_gain_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // hold the write until no item is in flight
    task automatic write_cfg(logic [2:0] idx, logic [47:0] v);
        while (sb.pending.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(logic [16:0] ramp, logic restart, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        repeat (g) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, restart, ramp};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(ramp, restart);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function logic [16:0] rand_ramp();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 17'd65536;
        if (k == 1) return 17'($urandom_range(65536, 131071));
        if (k == 2) return 17'($urandom_range(0, 15));
        return 17'($urandom_range(0, 65536));
    endfunction

    // random physical-ish setting: pressure usually nonzero, sometimes capped
    task automatic rand_setting(bit extreme);
        write_cfg(REG_ENABLE, 48'($urandom_range(0, 7) != 0));
        write_cfg(REG_SEED, ($urandom_range(0, 7) == 0) ? 48'd0 : 48'($urandom()));
        if (extreme) begin
            write_cfg(REG_FLOW, 48'hFFFF_FFFF);
            write_cfg(REG_INV_AREA, 48'hFFFF_FFFF);
            write_cfg(REG_GAIN, 48'hFFFF_FFFF_FFFF);
            write_cfg(REG_SLOW_COEF, 48'h1FF_FFFF);
            write_cfg(REG_FAST_COEF, 48'h1FF_FFFF);
            write_cfg(REG_NORM, 48'h7F_FFFF);
        end else begin
            write_cfg(REG_FLOW, 48'($urandom_range(1, 32'h0400_0000)));
            write_cfg(REG_INV_AREA, 48'($urandom_range(32'h0001_0000, 32'h0100_0000)));
            write_cfg(REG_GAIN, {16'd0, $urandom()} << $urandom_range(0, 16));
            write_cfg(REG_SLOW_COEF, 48'($urandom_range(0, 25'h1000000)));
            write_cfg(REG_FAST_COEF, 48'($urandom_range(0, 25'h1000000)));
            write_cfg(REG_NORM, 48'($urandom_range(0, 23'h400000)));
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = REG_ENABLE; i_cfg_data = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0;
        stim_done = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // disabled core, then ramp extremes at reset targets
        send_item(17'd0, 1'b0, 1'b0);
        send_item(17'h1FFFF, 1'b1, 1'b0);
        write_cfg(REG_ENABLE, 48'd1);
        send_item(17'd65536, 1'b0, 1'b0);
        // max targets: saturation, coef and norm above one, capped pressure
        rand_setting(1'b1);
        write_cfg(REG_ENABLE, 48'd1);
        write_cfg(REG_SEED, 48'hFFFF_FFFF);
        send_item(17'd0, 1'b1, 1'b0);
        repeat (6) send_item(17'h1FFFF, 1'b0, 1'b0);
        send_item(17'd1, 1'b0, 1'b0);
        drain();
        // zero pressure: gain zero holds the noise
        write_cfg(REG_GAIN, 48'd0);
        send_item(17'd65536, 1'b0, 1'b0);
        send_item(17'd65535, 1'b0, 1'b0);
        write_cfg(REG_GAIN, 48'hFFFF_FFFF_FFFF);
        write_cfg(REG_SEED, 48'd0);
        send_item(17'd0, 1'b1, 1'b0);
        send_item(17'd32768, 1'b0, 1'b0);
        write_cfg(REG_ENABLE, 48'd0);
        send_item(17'd65536, 1'b1, 1'b0);
        drain();
        // norm target above the usable maximum
        write_cfg(REG_NORM, 48'h7F_FFFF);

        for (int ph = 0; ph < 12; ph++) begin
            rand_setting(ph == 5);
            for (int i = 0; i < 50; i++)
                send_item(rand_ramp(), (i == 0) || ($urandom_range(0, 24) == 0), 1'b1);
            drain();
        end
        stim_done = 1;
    end

    initial begin
        m_axis_tready = 0;
        hold_rx = 0;
        rx_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            hold_rx = (rx_cycles > 3000) && (rx_cycles < 3800);
            if (hold_rx) m_axis_tready <= 0;
            else if (gap_len() != 0 && $urandom_range(0, 1)) m_axis_tready <= 0;
            else m_axis_tready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_sample(m_axis_tdata[33:0]);
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (stim_done) begin
                $display("covered %0d samples (%0d nonzero) over 12 random settings",
                         sb.checked, sb.nonzero);
                if (sb.errors == 0 && sb.pending.size() == 0)
                    $display("tb_banded_noise_synth_with_ramped_gain_core passed");
                else
                    $display("tb_banded_noise_synth_with_ramped_gain_core failed");
                $finish;
            end
            if (cycles > 600000) begin
                $display("timeout");
                $display("tb_banded_noise_synth_with_ramped_gain_core failed");
                $finish;
            end
        end
    end
endmodule

// ----- sim.f -----
rtl/core/bns_pkg.sv
rtl/core/bns_mul.sv
rtl/core/banded_noise_synth_with_ramped_gain_core.sv
tb/sv/tb_banded_noise_synth_with_ramped_gain_core.sv
